/* rtl/ttuv_pkg.sv */
// Shared types and fixed widths for the triangle tangent block.
// Used by the front end, the job queue and the back end; no dependencies.
package ttuv_pkg;

  localparam int POS_W  = 32;   // Q16.16 position
  localparam int UV_W   = 16;   // Q4.12 texture coordinate
  localparam int EDGE_W = 33;   // exact position difference
  localparam int DUV_W  = 17;   // exact UV difference
  localparam int PROD_W = 50;   // DUV_W x EDGE_W product
  localparam int DET_W  = 35;   // UV determinant
  localparam int WV_W   = 51;   // unscaled tangent component
  localparam int NORM_W = 30;   // magnitude after normalizing shift
  localparam int SQ_W   = 60;   // square of a normalized magnitude
  localparam int SUM_W  = 62;   // sum of three squares
  localparam int LEN_W  = 32;   // vector length
  localparam int NUM_W  = 46;   // rounded dividend
  localparam int MAG_W  = 15;   // quotient, at most one in Q1.14
  localparam int TAN_W  = 16;   // Q1.14 output component
  localparam int Q14_SH = 14;

  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 48;

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  // One triangle ready for the back end.
  typedef struct packed {
    logic [2:0][EDGE_W-1:0] e1;
    logic [2:0][EDGE_W-1:0] e2;
    logic [DUV_W-1:0]       du1;
    logic [DUV_W-1:0]       dv1;
    logic [DUV_W-1:0]       du2;
    logic [DUV_W-1:0]       dv2;
  } job_t;

endpackage

/* rtl/ttuv_front.sv */
// Front end: takes vertices, holds the first two of each triangle and
// forms edge vectors and UV deltas on the third. Depends on ttuv_pkg.
module ttuv_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ttuv_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                             job_valid,
  input  logic                             job_ready,
  output ttuv_pkg::job_t                   job
);

  logic [1:0]                    phase_r, phase_nxt;
  logic [ttuv_pkg::POS_W-1:0]    p0_r [3];
  logic [ttuv_pkg::POS_W-1:0]    p1_r [3];
  logic [ttuv_pkg::UV_W-1:0]     u0_r, v0_r, u1_r, v1_r;
  logic [ttuv_pkg::POS_W-1:0]    pin [3];
  logic [ttuv_pkg::UV_W-1:0]     uin, vin;
  logic                          accept;
  logic                          first;

  assign pin[0] = in_tdata[31:0];
  assign pin[1] = in_tdata[63:32];
  assign pin[2] = in_tdata[95:64];
  assign uin    = in_tdata[111:96];
  assign vin    = in_tdata[127:112];

  // unreachable phase three starts a new triangle
  assign first     = (phase_r != ttuv_pkg::PH_SECOND) && (phase_r != ttuv_pkg::PH_THIRD);
  assign in_tready = (phase_r != ttuv_pkg::PH_THIRD) || job_ready;
  assign job_valid = in_tvalid && (phase_r == ttuv_pkg::PH_THIRD);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      job.e1[i] = {p1_r[i][ttuv_pkg::POS_W-1], p1_r[i]} - {p0_r[i][ttuv_pkg::POS_W-1], p0_r[i]};
      job.e2[i] = {pin[i][ttuv_pkg::POS_W-1], pin[i]} - {p0_r[i][ttuv_pkg::POS_W-1], p0_r[i]};
    end
    job.du1 = {u1_r[ttuv_pkg::UV_W-1], u1_r} - {u0_r[ttuv_pkg::UV_W-1], u0_r};
    job.dv1 = {v1_r[ttuv_pkg::UV_W-1], v1_r} - {v0_r[ttuv_pkg::UV_W-1], v0_r};
    job.du2 = {uin[ttuv_pkg::UV_W-1], uin} - {u0_r[ttuv_pkg::UV_W-1], u0_r};
    job.dv2 = {vin[ttuv_pkg::UV_W-1], vin} - {v0_r[ttuv_pkg::UV_W-1], v0_r};
  end

  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      if (first) begin
        phase_nxt = ttuv_pkg::PH_SECOND;
      end else if (phase_r == ttuv_pkg::PH_SECOND) begin
        phase_nxt = ttuv_pkg::PH_THIRD;
      end else begin
        phase_nxt = ttuv_pkg::PH_FIRST;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ttuv_pkg::PH_FIRST;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && first) begin
      for (int i = 0; i < 3; i++) p0_r[i] <= pin[i];
      u0_r <= uin;
      v0_r <= vin;
    end
    if (accept && phase_r == ttuv_pkg::PH_SECOND) begin
      for (int i = 0; i < 3; i++) p1_r[i] <= pin[i];
      u1_r <= uin;
      v1_r <= vin;
    end
  end

endmodule

/* rtl/ttuv_queue.sv */
// Short job queue between front and back end.
// Depends on ttuv_pkg for the job type.
module ttuv_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  ttuv_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output ttuv_pkg::job_t pop_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ttuv_pkg::job_t     mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_job    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

/* rtl/ttuv_back.sv */
// Back end: determinant and unscaled tangent on a shared multiplier, then, if
// not degenerate, normalize, bit-serial square root and three serial divides. Uses ttuv_pkg.
module ttuv_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              job_valid,
  output logic                              job_ready,
  input  ttuv_pkg::job_t                    job,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ttuv_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tuser
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_MUL      = 9'b000000010,
    S_CHK      = 9'b000000100,
    S_SHIFT    = 9'b000001000,
    S_SQ       = 9'b000010000,
    S_ROOT     = 9'b000100000,
    S_DIV_INIT = 9'b001000000,
    S_DIV      = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_t;

  state_t                             state_r;
  ttuv_pkg::job_t                     job_r;
  logic [4:0]                         cnt_r;
  logic [1:0]                         comp_r;
  logic signed [ttuv_pkg::PROD_W-1:0] prod_r, tmp_r;
  logic [ttuv_pkg::DET_W-1:0]         det_r;
  logic [ttuv_pkg::WV_W-1:0]          w_r [3];
  logic [ttuv_pkg::WV_W-1:0]          a_r [3];
  logic [2:0]                         neg_r;
  logic [ttuv_pkg::SQ_W-1:0]          sq_r;
  logic [ttuv_pkg::SUM_W-1:0]         sum_r;
  logic [ttuv_pkg::SUM_W-1:0]         root_r;
  logic [ttuv_pkg::NUM_W-1:0]         rem_r;
  logic [ttuv_pkg::MAG_W-1:0]         quo_r;
  logic [ttuv_pkg::TAN_W-1:0]         tan_r [3];
  logic                               deg_r;
  logic                               out_valid_r;
  logic [ttuv_pkg::OUT_DATA_W-1:0]    out_data_r;
  logic                               out_user_r;

  logic signed [ttuv_pkg::DUV_W-1:0]  ma;
  logic signed [ttuv_pkg::EDGE_W-1:0] mb;
  logic signed [ttuv_pkg::PROD_W-1:0] mprod;
  logic [ttuv_pkg::WV_W-1:0]          diff;
  logic [2:0]                         step;
  logic [ttuv_pkg::WV_W-1:0]          a_sel;
  logic [ttuv_pkg::SUM_W-1:0]         rbit, trial;
  logic [ttuv_pkg::LEN_W-1:0]         len;
  logic [ttuv_pkg::NUM_W-1:0]         den_sh;
  logic [ttuv_pkg::MAG_W-1:0]         quo_fin;
  logic [ttuv_pkg::TAN_W-1:0]         tan_val;
  logic                               w_zero, big, load_out;

  assign job_ready = (state_r == S_IDLE);
  assign step      = cnt_r[2:0] - 3'd1;

  // multiplier operands by step: det terms, then W terms per axis
  always_comb begin
    case (cnt_r[2:0])
      3'd0:    begin ma = job_r.du1; mb = {{16{job_r.dv2[16]}}, job_r.dv2}; end
      3'd1:    begin ma = job_r.du2; mb = {{16{job_r.dv1[16]}}, job_r.dv1}; end
      3'd2:    begin ma = job_r.dv2; mb = job_r.e1[0]; end
      3'd3:    begin ma = job_r.dv1; mb = job_r.e2[0]; end
      3'd4:    begin ma = job_r.dv2; mb = job_r.e1[1]; end
      3'd5:    begin ma = job_r.dv1; mb = job_r.e2[1]; end
      3'd6:    begin ma = job_r.dv2; mb = job_r.e1[2]; end
      default: begin ma = job_r.dv1; mb = job_r.e2[2]; end
    endcase
  end
  assign mprod = ma * mb;
  assign diff  = {tmp_r[ttuv_pkg::PROD_W-1], tmp_r} - {prod_r[ttuv_pkg::PROD_W-1], prod_r};

  assign w_zero = (w_r[0] == '0) && (w_r[1] == '0) && (w_r[2] == '0);
  assign big    = (a_r[0][ttuv_pkg::WV_W-1:ttuv_pkg::NORM_W] != '0) ||
                  (a_r[1][ttuv_pkg::WV_W-1:ttuv_pkg::NORM_W] != '0) ||
                  (a_r[2][ttuv_pkg::WV_W-1:ttuv_pkg::NORM_W] != '0);

  always_comb begin
    case (state_r)
      S_SQ:    a_sel = (cnt_r[1:0] == 2'd0) ? a_r[0] : (cnt_r[1:0] == 2'd1) ? a_r[1] : a_r[2];
      default: a_sel = (comp_r == 2'd0) ? a_r[0] : (comp_r == 2'd1) ? a_r[1] : a_r[2];
    endcase
  end

  assign rbit   = ttuv_pkg::SUM_W'(1) << {cnt_r, 1'b0};
  assign trial  = root_r + rbit;
  assign len    = root_r[ttuv_pkg::LEN_W-1:0];
  assign den_sh = ttuv_pkg::NUM_W'(len) << cnt_r;

  always_comb begin
    quo_fin = quo_r;
    if (rem_r >= den_sh) quo_fin = quo_r | (ttuv_pkg::MAG_W'(1) << cnt_r);
  end

  assign tan_val = neg_r[comp_r] ? ttuv_pkg::TAN_W'(0) - {1'b0, quo_fin}
                                 : {1'b0, quo_fin};
  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE:     if (job_valid) state_r <= S_MUL;
        S_MUL:      if (cnt_r == 5'd8) state_r <= S_CHK;
        S_CHK:      state_r <= ((det_r == '0) || w_zero) ? S_DONE : S_SHIFT;
        S_SHIFT:    if (!big) state_r <= S_SQ;
        S_SQ:       if (cnt_r == 5'd3) state_r <= S_ROOT;
        S_ROOT:     if (cnt_r == 5'd0) state_r <= S_DIV_INIT;
        S_DIV_INIT: state_r <= S_DIV;
        S_DIV:      if (cnt_r == 5'd0 && comp_r == 2'd2) begin
                      state_r <= S_DONE;
                    end else if (cnt_r == 5'd0) begin
                      state_r <= S_DIV_INIT;
                    end
        S_DONE:     if (load_out) state_r <= S_IDLE;
        default:    state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        job_r <= job;
        cnt_r <= '0;
      end
      S_MUL: begin
        cnt_r  <= cnt_r + 1'b1;
        prod_r <= mprod;
        if (cnt_r != '0) begin
          if (!step[0]) begin
            tmp_r <= prod_r;
          end else begin
            case (step[2:1])
              2'd0:    det_r <= diff[ttuv_pkg::DET_W-1:0];
              2'd1:    w_r[0] <= diff;
              2'd2:    w_r[1] <= diff;
              default: w_r[2] <= diff;
            endcase
          end
        end
      end
      S_CHK: begin
        for (int i = 0; i < 3; i++) begin
          a_r[i]   <= w_r[i][ttuv_pkg::WV_W-1] ? ttuv_pkg::WV_W'(0) - w_r[i] : w_r[i];
          neg_r[i] <= w_r[i][ttuv_pkg::WV_W-1] ^ det_r[ttuv_pkg::DET_W-1];
          tan_r[i] <= '0;
        end
        deg_r <= (det_r == '0) || w_zero;
        cnt_r <= '0;
        sum_r <= '0;
      end
      S_SHIFT: begin
        // drop one low bit per cycle until the largest magnitude fits
        if (big) begin
          for (int i = 0; i < 3; i++) a_r[i] <= a_r[i] >> 1;
        end
      end
      S_SQ: begin
        cnt_r <= cnt_r + 1'b1;
        sq_r  <= a_sel[ttuv_pkg::NORM_W-1:0] * a_sel[ttuv_pkg::NORM_W-1:0];
        if (cnt_r != '0) sum_r <= sum_r + ttuv_pkg::SUM_W'(sq_r);
        if (cnt_r == 5'd3) begin
          cnt_r  <= 5'd30;
          root_r <= '0;
        end
      end
      S_ROOT: begin
        if (sum_r >= trial) begin
          sum_r  <= sum_r - trial;
          root_r <= (root_r >> 1) + rbit;
        end else begin
          root_r <= root_r >> 1;
        end
        cnt_r  <= cnt_r - 1'b1;
        comp_r <= 2'd0;
      end
      S_DIV_INIT: begin
        rem_r <= {2'b00, a_sel[ttuv_pkg::NORM_W-1:0], {ttuv_pkg::Q14_SH{1'b0}}}
                 + ttuv_pkg::NUM_W'(len >> 1);
        quo_r <= '0;
        cnt_r <= 5'(ttuv_pkg::MAG_W - 1);
      end
      S_DIV: begin
        if (rem_r >= den_sh) rem_r <= rem_r - den_sh;
        quo_r <= quo_fin;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          tan_r[comp_r] <= tan_val;
          comp_r        <= comp_r + 1'b1;
        end
      end
      S_DONE: begin
        if (load_out) begin
          out_data_r <= {tan_r[2], tan_r[1], tan_r[0]};
          out_user_r <= deg_r;
        end
      end
      default: cnt_r <= '0;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

/* rtl/triangle_tangent_from_uv_core.sv */
// Channel   Dir  tdata fields (low bit first)                          tuser
// in_       in   pos_x[31:0] pos_y[63:32] pos_z[95:64] tex_u tex_v     -
// out_      out  tangent_x[15:0] tangent_y[31:16] tangent_z[47:32]     degenerate
// The first two vertices of a triangle are taken whenever offered; the third waits for room in the job queue.
// The back end holds one triangle through the multiply, check, shift, square, square-root
// and three divide steps and takes no new job until it hands the result off; a degenerate
// triangle goes from the check straight to hand-off. The shared multiplier and the serial
// root and divider set the pace. Reset is synchronous, active low; it empties the
// queue and the output register. Either side may stall; the queue and output register
// decouple them.
module triangle_tangent_from_uv_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ttuv_pkg::IN_DATA_W-1:0]    in_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ttuv_pkg::OUT_DATA_W-1:0]   out_tdata,  // tangent_x, tangent_y, tangent_z
  output logic                              out_tuser   // degenerate
);

  ttuv_pkg::job_t push_job, pop_job;
  logic           push_valid, push_ready, pop_valid, pop_ready;

  ttuv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .job_valid (push_valid),
    .job_ready (push_ready),
    .job       (push_job)
  );

  ttuv_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  ttuv_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (pop_valid),
    .job_ready  (pop_ready),
    .job        (pop_job),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

/* rtl/ttuv_checker.sv */
// Port-level checks for the triangle tangent block, bound to the top level.
// Depends on ttuv_pkg for channel widths.
module ttuv_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [ttuv_pkg::IN_DATA_W-1:0]    in_tdata,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [ttuv_pkg::OUT_DATA_W-1:0]   out_tdata,
  input logic                              out_tuser
);

  // a degenerate triangle carries a zero vector
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("degenerate result with nonzero vector");

  // every component of a unit tangent stays within one in Q1.14
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |->
      ($signed(out_tdata[15:0]) <= 16384) && ($signed(out_tdata[15:0]) >= -16384) &&
      ($signed(out_tdata[31:16]) <= 16384) && ($signed(out_tdata[31:16]) >= -16384) &&
      ($signed(out_tdata[47:32]) <= 16384) && ($signed(out_tdata[47:32]) >= -16384))
    else $error("tangent component out of range");

  // nothing is pending right after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_tvalid)
    else $error("result shown right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind triangle_tangent_from_uv_core ttuv_checker u_ttuv_checker (.*);
